FILE: hw/rtl/ecc_pkg.sv
// ============================================================================
// ecc_pkg: shared types, constants and small tables for the epoch/calendar converter
// Reciprocal constants for the constant dividers, the saturation helper and the
// date/time-of-day bundles that pass between the pipeline modules.
// ============================================================================
package ecc_pkg;

    localparam logic [37:0] EpochMax   = 38'd253402300799;
    localparam logic [16:0] SecsPerDay = 17'd86400;
    localparam logic [23:0] DaysTo1970 = 24'd719561;

    // floor(x / d) == (x * R) >> S, with R = ceil(2^S / d), exact over each value range
    localparam logic [14:0] R100    = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
    localparam logic [31:0] R675    = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
    localparam logic [24:0] R146097 = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
    localparam logic [27:0] R7305   = 28'(((64'd1 << 40) + 64'd7304) / 64'd7305);
    localparam logic [29:0] K30601  = 30'(64'd1000 * (((64'd1 << 34) + 64'd30600) / 64'd30601));
    localparam logic [17:0] R3600   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [12:0] R60     = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [16:0] sod;
    } t_tod;

    // saturate a signed count to [0, EpochMax]
    function automatic logic [37:0] ecc_clamp(input logic signed [41:0] v);
        logic [37:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({4'd0, EpochMax})) begin
            res = EpochMax;
        end else begin
            res = v[37:0];
        end
        return res;
    endfunction

    // 30*m + 3*(m+1)/5 with Jan/Feb taken as months 13/14
    function automatic logic [8:0] ecc_month_term(input logic [3:0] mon);
        logic [8:0] res;
        unique case (mon)
            4'd1:    res = 9'd398;
            4'd2:    res = 9'd429;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd123;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd276;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            4'd12:   res = 9'd367;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    // floor(e * 601 / 1000)
    function automatic logic [3:0] ecc_e601(input logic [4:0] e);
        logic [3:0] res;
        unique case (e)
            5'd0, 5'd1:          res = 4'd0;
            5'd2, 5'd3:          res = 4'd1;
            5'd4:                res = 4'd2;
            5'd5, 5'd6:          res = 4'd3;
            5'd7, 5'd8:          res = 4'd4;
            5'd9:                res = 4'd5;
            5'd10, 5'd11:        res = 4'd6;
            5'd12, 5'd13:        res = 4'd7;
            5'd14:               res = 4'd8;
            5'd15, 5'd16:        res = 4'd9;
            5'd17:               res = 4'd10;
            default:             res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

FILE: hw/rtl/epoch_calendar_converter_top.sv
// ============================================================================
// epoch_calendar_converter_top: calendar <-> seconds-since-1970 converter
// Nine-stage pipeline, one conversion per cycle unless m_axis stalls, with a local-offset register.
// ============================================================================
// Usage:
//  - Input stream (s_axis): one transaction per conversion. tuser[0] selects
//    the operation (0: calendar fields to epoch count, 1: epoch count to
//    calendar fields), tuser[1] marks the count as UTC so the local offset
//    applies. Unused fields of the other operation are ignored.
//  - Output stream (m_axis): one transaction per input transaction, in order,
//    carrying the epoch count, the local calendar fields and seconds of day.
//  - Config channel: a write of the signed 17-bit local offset (seconds). It
//    is always ready; write it only while no conversion is in flight.
//  - Throughput is one transaction per cycle while m_axis accepts; depth is
//    set by the chain of constant divisions (days, hours, minutes; 146097,
//    7305, 30601 for the date).
//  - Each stage has its own valid bit and its own enable, so a stall on
//    m_axis fills bubbles first and only then deasserts s_axis tready; no
//    transaction is lost or duplicated.
//  - Synchronous active-low reset clears all valid bits and the offset to 0.
// ============================================================================
module epoch_calendar_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [13:0] in_year, [17:14] in_month, [22:18] in_day, [27:23] in_hour,
    // [33:28] in_minute, [39:34] in_second, [77:40] in_epoch_count, [79:78] zero
    input  logic [79:0] i_s_axis_tdata,
    // [0] operation, [1] is_utc
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [37:0] epoch_count, [51:38] cal_year, [55:52] cal_month, [60:56] cal_day,
    // [65:61] cal_hour, [71:66] cal_minute, [77:72] cal_second,
    // [94:78] seconds_of_day, [95] zero
    output logic [95:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    logic [8:0] w_en;
    logic [8:0] r_vld;
    logic [7:0] r_op;
    logic [7:0] r_utc;
    logic signed [16:0] r_offset;

    logic [37:0]    w_floc;
    ecc_pkg::t_date w_fdate;
    ecc_pkg::t_tod  w_ftod;
    logic [21:0]    w_days;
    logic [37:0]    w_sloc;
    ecc_pkg::t_tod  w_stod;
    ecc_pkg::t_date w_cdate;

    logic [37:0]    n_loc;
    logic [37:0]    n_ep;
    ecc_pkg::t_date n_date;
    ecc_pkg::t_tod  n_tod;
    logic signed [41:0] n_diff;

    logic [37:0]    r_ep;
    ecc_pkg::t_date r_date;
    ecc_pkg::t_tod  r_tod;

    // stage k advances when empty or when stage k+1 advances
    always_comb begin
        w_en[8] = !r_vld[8] || i_m_axis_tready;
        for (int k = 7; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_offset <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < 9; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_offset <= i_cfg_data;
            end
        end
    end

    // operation and UTC flag ride alongside the datapath
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_op[0]  <= i_s_axis_tuser[0];
            r_utc[0] <= i_s_axis_tuser[1];
        end
        for (int k = 1; k < 8; k++) begin
            if (w_en[k]) begin
                r_op[k]  <= r_op[k-1];
                r_utc[k] <= r_utc[k-1];
            end
        end
    end

    ecc_fwd u_fwd (
        .i_clk    (i_clk),
        .i_en     (w_en[7:0]),
        .i_year   (i_s_axis_tdata[13:0]),
        .i_month  (i_s_axis_tdata[17:14]),
        .i_day    (i_s_axis_tdata[22:18]),
        .i_hour   (i_s_axis_tdata[27:23]),
        .i_minute (i_s_axis_tdata[33:28]),
        .i_second (i_s_axis_tdata[39:34]),
        .o_loc    (w_floc),
        .o_date   (w_fdate),
        .o_tod    (w_ftod)
    );

    ecc_split u_split (
        .i_clk    (i_clk),
        .i_en     (w_en[7:0]),
        .i_epoch  (i_s_axis_tdata[77:40]),
        .i_utc    (i_s_axis_tuser[1]),
        .i_offset (r_offset),
        .o_days   (w_days),
        .o_loc    (w_sloc),
        .o_tod    (w_stod)
    );

    ecc_civil u_civil (
        .i_clk  (i_clk),
        .i_en   (w_en[7:2]),
        .i_days (w_days),
        .o_date (w_cdate)
    );

    // output stage: pick the path, convert local count back to UTC if flagged
    always_comb begin
        n_loc  = r_op[7] ? w_sloc  : w_floc;
        n_date = r_op[7] ? w_cdate : w_fdate;
        n_tod  = r_op[7] ? w_stod  : w_ftod;
        n_diff = $signed({4'd0, n_loc}) - $signed({{25{r_offset[16]}}, r_offset});
        n_ep   = r_utc[7] ? ecc_pkg::ecc_clamp(n_diff) : n_loc;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_ep   <= n_ep;
            r_date <= n_date;
            r_tod  <= n_tod;
        end
    end

    assign o_m_axis_tvalid = r_vld[8];
    assign o_m_axis_tdata  = {1'b0, r_tod.sod, r_tod.second, r_tod.minute, r_tod.hour,
                              r_date.day, r_date.month, r_date.year, r_ep};

endmodule

FILE: hw/rtl/ecc_fwd.sv
// ============================================================================
// ecc_fwd: calendar fields to local epoch count
// Cleans the fields, forms the day number and the saturated second count.
// ============================================================================
module ecc_fwd (
    input  logic                 i_clk,
    input  logic [7:0]           i_en,
    input  logic [13:0]          i_year,
    input  logic [3:0]           i_month,
    input  logic [4:0]           i_day,
    input  logic [4:0]           i_hour,
    input  logic [5:0]           i_minute,
    input  logic [5:0]           i_second,
    output logic [37:0]          o_loc,
    output ecc_pkg::t_date       o_date,
    output ecc_pkg::t_tod        o_tod
);

    logic [3:0]  n_mon;
    logic [4:0]  n_day;
    logic [4:0]  n_hr;
    logic [5:0]  n_mi;
    logic [5:0]  n_se;
    logic        n_early;
    logic        n_yneg;
    logic [13:0] n_ypos;
    logic [28:0] n_p100;
    logic [23:0] n_base;
    logic [23:0] n_days;
    logic signed [41:0] n_lc;

    ecc_pkg::t_date r_date [0:7];
    ecc_pkg::t_tod  r_tod  [0:7];
    logic [13:0]    r_ypos;
    logic [7:0]     r_q100;
    logic           r_yneg;
    logic [23:0]    r_days;
    logic signed [41:0] r_lc;
    logic [37:0]    r_loc [3:7];

    always_comb begin
        n_mon   = (i_month == 4'd0 || i_month > 4'd12) ? 4'd1 : i_month;
        n_day   = (i_day == 5'd0) ? 5'd1 : i_day;
        n_hr    = (i_hour > 5'd23) ? 5'd0 : i_hour;
        n_mi    = (i_minute > 6'd59) ? 6'd0 : i_minute;
        n_se    = (i_second > 6'd59) ? 6'd0 : i_second;
        n_early = (n_mon <= 4'd2);
        n_yneg  = n_early && (i_year == 14'd0);
        n_ypos  = n_yneg ? 14'd0 : (i_year - 14'(n_early));
        n_p100  = 29'(n_ypos) * 29'(ecc_pkg::R100);
    end

    always_comb begin
        n_base = 24'(r_ypos) * 24'd365 + 24'(r_ypos >> 2) - 24'(r_q100) + 24'(r_q100 >> 2);
        if (r_yneg) begin
            n_base = 24'd0 - 24'd365;
        end
        n_days = n_base + 24'(ecc_pkg::ecc_month_term(r_date[0].month))
               + 24'(r_date[0].day) - ecc_pkg::DaysTo1970;
        n_lc   = $signed({{18{r_days[23]}}, r_days}) * $signed(42'd86400)
               + $signed({25'd0, r_tod[1].sod});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_date[0] <= '{year: i_year, month: n_mon, day: n_day};
            r_tod[0]  <= '{hour: n_hr, minute: n_mi, second: n_se,
                           sod: 17'(n_hr) * 17'd3600 + 17'(n_mi) * 17'd60 + 17'(n_se)};
            r_ypos    <= n_ypos;
            r_q100    <= n_p100[28:21];
            r_yneg    <= n_yneg;
        end
        if (i_en[1]) begin
            r_days <= n_days;
        end
        if (i_en[2]) begin
            r_lc <= n_lc;
        end
        if (i_en[3]) begin
            r_loc[3] <= ecc_pkg::ecc_clamp(r_lc);
        end
        for (int k = 1; k < 8; k++) begin
            if (i_en[k]) begin
                r_date[k] <= r_date[k-1];
                r_tod[k]  <= r_tod[k-1];
            end
        end
        for (int k = 4; k < 8; k++) begin
            if (i_en[k]) begin
                r_loc[k] <= r_loc[k-1];
            end
        end
    end

    assign o_loc  = r_loc[7];
    assign o_date = r_date[7];
    assign o_tod  = r_tod[7];

endmodule

FILE: hw/rtl/ecc_split.sv
// ============================================================================
// ecc_split: epoch count to day number and time of day
// Applies the offset when flagged UTC, saturates, then peels off days, hours, minutes, seconds.
// ============================================================================
module ecc_split (
    input  logic                 i_clk,
    input  logic [7:0]           i_en,
    input  logic [37:0]          i_epoch,
    input  logic                 i_utc,
    input  logic signed [16:0]   i_offset,
    output logic [21:0]          o_days,
    output logic [37:0]          o_loc,
    output ecc_pkg::t_tod        o_tod
);

    logic signed [41:0] n_raw;
    logic [62:0] n_pd;
    logic [37:0] n_sod;
    logic [34:0] n_ph;
    logic [16:0] n_r;
    logic [24:0] n_pm;

    logic [37:0] r_t [0:7];
    logic [21:0] r_d;
    logic [16:0] r_sod [2:7];
    logic [4:0]  r_hr  [3:7];
    logic [11:0] r_r   [4:5];
    logic [5:0]  r_mi  [5:7];
    logic [5:0]  r_se  [6:7];

    always_comb begin
        n_raw = $signed({4'd0, i_epoch});
        if (i_utc) begin
            n_raw = n_raw + $signed({{25{i_offset[16]}}, i_offset});
        end
        n_pd  = 63'(r_t[0][37:7]) * 63'(ecc_pkg::R675);
        n_sod = r_t[1] - 38'(r_d) * 38'(ecc_pkg::SecsPerDay);
        n_ph  = 35'(r_sod[2]) * 35'(ecc_pkg::R3600);
        n_r   = r_sod[3] - 17'(r_hr[3]) * 17'd3600;
        n_pm  = 25'(r_r[4]) * 25'(ecc_pkg::R60);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t[0] <= ecc_pkg::ecc_clamp(n_raw);
        end
        if (i_en[1]) begin
            r_d <= n_pd[62:41];
        end
        if (i_en[2]) begin
            r_sod[2] <= n_sod[16:0];
        end
        if (i_en[3]) begin
            r_hr[3] <= n_ph[33:29];
        end
        if (i_en[4]) begin
            r_r[4] <= n_r[11:0];
        end
        if (i_en[5]) begin
            r_mi[5] <= n_pm[23:18];
            r_r[5]  <= r_r[4];
        end
        if (i_en[6]) begin
            r_se[6] <= 6'(r_r[5] - 12'(r_mi[5]) * 12'd60);
        end
        for (int k = 1; k < 8; k++) begin
            if (i_en[k]) begin
                r_t[k] <= r_t[k-1];
            end
        end
        for (int k = 3; k < 8; k++) begin
            if (i_en[k]) begin
                r_sod[k] <= r_sod[k-1];
            end
        end
        for (int k = 4; k < 8; k++) begin
            if (i_en[k]) begin
                r_hr[k] <= r_hr[k-1];
            end
        end
        for (int k = 6; k < 8; k++) begin
            if (i_en[k]) begin
                r_mi[k] <= r_mi[k-1];
            end
        end
        if (i_en[7]) begin
            r_se[7] <= r_se[6];
        end
    end

    assign o_days = r_d;
    assign o_loc  = r_t[7];
    assign o_tod  = '{hour: r_hr[7], minute: r_mi[7], second: r_se[7], sod: r_sod[7]};

endmodule

FILE: hw/rtl/ecc_civil.sv
// ============================================================================
// ecc_civil: day number to Gregorian year, month, day
// Six stages; the constant divisions by 146097, 7305 and 30601 use reciprocal multiply.
// ============================================================================
module ecc_civil (
    input  logic                 i_clk,
    input  logic [5:0]           i_en,
    input  logic [21:0]          i_days,
    output ecc_pkg::t_date       o_date
);

    logic [23:0] n_na;
    logic [48:0] n_pa;
    logic [22:0] n_b;
    logic [27:0] n_nc;
    logic [55:0] n_pc;
    logic [22:0] n_dd;
    logic [38:0] n_pe;
    logic [8:0]  n_f;

    logic [21:0] r_days;
    logic [6:0]  r_a;
    logic [22:0] r_b [1:2];
    logic [13:0] r_c [2:4];
    logic [8:0]  r_d [3:4];
    logic [4:0]  r_e;
    ecc_pkg::t_date r_date;

    always_comb begin
        n_na = {i_days, 2'b00} + 24'd102032;
        n_pa = 49'(n_na) * 49'(ecc_pkg::R146097);
        n_b  = 23'(r_days) + 23'd2442113 + 23'(r_a) - 23'(r_a >> 2);
        n_nc = 28'(r_b[1]) * 28'd20 - 28'd2442;
        n_pc = 56'(n_nc) * 56'(ecc_pkg::R7305);
        n_dd = r_b[2] - 23'(r_c[2]) * 23'd365 - 23'(r_c[2] >> 2);
        n_pe = 39'(r_d[3]) * 39'(ecc_pkg::K30601);
        n_f  = r_d[4] - 9'(r_e) * 9'd30 - 9'(ecc_pkg::ecc_e601(r_e));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_days <= i_days;
            r_a    <= n_pa[48:42] + 7'd15;
        end
        if (i_en[1]) begin
            r_b[1] <= n_b;
        end
        if (i_en[2]) begin
            r_c[2] <= n_pc[53:40];
            r_b[2] <= r_b[1];
        end
        if (i_en[3]) begin
            r_d[3] <= n_dd[8:0];
            r_c[3] <= r_c[2];
        end
        if (i_en[4]) begin
            r_e    <= n_pe[38:34];
            r_d[4] <= r_d[3];
            r_c[4] <= r_c[3];
        end
        if (i_en[5]) begin
            // months March..December map to e <= 13, January and February wrap to the next year
            if (r_e <= 5'd13) begin
                r_date <= '{year: r_c[4] - 14'd4716, month: 4'(r_e - 5'd1), day: n_f[4:0]};
            end else begin
                r_date <= '{year: r_c[4] - 14'd4715, month: 4'(r_e - 5'd13), day: n_f[4:0]};
            end
        end
    end

    assign o_date = r_date;

endmodule
